FILE: src/tql_pkg.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning package
// Shared constants, types, codes and helper functions of the agent.
// ----------------------------------------------------------------------------
`default_nettype none

package tql_pkg;

  localparam int NUM_STATES   = 4096;
  localparam int MAX_ACTIONS  = 16;
  localparam int STATE_W      = $clog2(NUM_STATES);
  localparam int ACT_W        = $clog2(MAX_ACTIONS);
  localparam int CNT_W        = $clog2(MAX_ACTIONS + 1);
  localparam int Q_W          = 32;
  localparam int RATE_W       = 17;
  localparam int MASK_W       = 16;
  localparam int DRAW_W       = 16;
  localparam int DRAW_IDX_W   = $clog2(DRAW_W);
  localparam int Q_ADDR_W     = STATE_W + ACT_W;
  localparam int Q_DEPTH      = NUM_STATES * MAX_ACTIONS;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = 3;
  localparam int PROD_W       = 51;
  localparam int SCALED_W     = 35;
  localparam int WIDE_W       = 36;

  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(65536);

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXPLORE_RATE    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STARTING_VALUE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RULE_SELECT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ACTIONS_IN_USE  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_AVAIL = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic KIND_ACT    = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;
  localparam logic RULE_STD    = 1'b0;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_NS_RD, S_NS_CHK, S_NS_SCAN, S_TCH_RD, S_TCH_CHK,
    S_FILL, S_MASK, S_DECIDE, S_DIV, S_SCAN_INIT, S_SCAN, S_OLD_RD, S_TGT,
    S_MUL2, S_WB, S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                     kind;
    logic [11:0]              state_index;
    logic [11:0]              next_state_index;
    logic [3:0]               action_taken;
    logic signed [31:0]       reward_value;
    logic                     episode_ended;
    logic                     training_on;
    logic [15:0]              action_mask;
    logic [15:0]              explore_draw;
    logic [15:0]              pick_draw;
  } in_item_t;

  typedef struct packed {
    logic [3:0] chosen_action;
    logic [1:0] status_code;
  } out_item_t;

  typedef struct packed {
    logic [RATE_W-1:0]  learning_rate;
    logic [RATE_W-1:0]  discount_factor;
    logic [RATE_W-1:0]  explore_rate;
    logic signed [31:0] starting_value;
    logic               rule_select;
    logic [4:0]         actions_in_use;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic ns_rd;
    logic tch_rd;
    logic avail_ld;
    logic fill;
    logic mark;
    logic mask_wr;
    logic div_start;
    logic div_run;
    logic scan_start;
    logic sel_mode;
    logic use_ns;
    logic scan_run;
    logic mq_ld;
    logic old_rd;
    logic mul_disc;
    logic tgt_ld;
    logic mul_alpha;
    logic q_wb;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic kind;
    logic ended;
    logic seen;
    logic fill_last;
    logic explore;
    logic cnt_zero;
    logic div_last;
    logic scan_done;
    logic a_oor;
  } sts_t;

  function automatic logic [RATE_W-1:0] sat_rate(input logic [RATE_W-1:0] r);
    return r[RATE_W-1] ? RATE_ONE : r;
  endfunction

  // Action count clamped to 1..MAX_ACTIONS.
  function automatic logic [CNT_W-1:0] used_count(input logic [4:0] c);
    logic [CNT_W-1:0] r;
    if (c == 5'd0) r = CNT_W'(1);
    else if (32'(c) > MAX_ACTIONS) r = CNT_W'(MAX_ACTIONS);
    else r = CNT_W'(c);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] popcount(input logic [MAX_ACTIONS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_ACTIONS; i++) c = c + CNT_W'(v[i]);
    return c;
  endfunction

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > WIDE_W'(signed'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
    else if (v < WIDE_W'(signed'(32'sh80000000))) r = 32'sh80000000;
    else r = v[Q_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/tql_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel that carries one item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tql_in_if;
  logic               valid;
  logic               ready;
  tql_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tql_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tql_out_if;
  logic               valid;
  logic               ready;
  tql_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tql_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/tql_ctrl.sv
// ----------------------------------------------------------------------------
// Q-learning controller
// State machine that sequences the datapath through one item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tql_pkg::sts_t sts_i,
  output tql_pkg::cmd_t      cmd_o
);

  tql_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  tql_pkg::ctrl_state_e after_touch;

  // Where an item goes once its current row exists.
  always_comb begin
    if (sts_i.kind == tql_pkg::KIND_ACT) after_touch = tql_pkg::S_MASK;
    else if (sts_i.a_oor) after_touch = tql_pkg::S_DONE;
    else after_touch = tql_pkg::S_OLD_RD;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tql_pkg::S_CLEAR:     if (sts_i.clr_last) state_d = tql_pkg::S_IDLE;
      tql_pkg::S_IDLE:      if (in_valid_i) state_d = tql_pkg::S_START;
      tql_pkg::S_START: begin
        if (sts_i.kind == tql_pkg::KIND_UPDATE && !sts_i.ended) state_d = tql_pkg::S_NS_RD;
        else state_d = tql_pkg::S_TCH_RD;
      end
      tql_pkg::S_NS_RD:     state_d = tql_pkg::S_NS_CHK;
      tql_pkg::S_NS_CHK:    state_d = sts_i.seen ? tql_pkg::S_NS_SCAN : tql_pkg::S_TCH_RD;
      tql_pkg::S_NS_SCAN:   if (sts_i.scan_done) state_d = tql_pkg::S_TCH_RD;
      tql_pkg::S_TCH_RD:    state_d = tql_pkg::S_TCH_CHK;
      tql_pkg::S_TCH_CHK:   state_d = sts_i.seen ? after_touch : tql_pkg::S_FILL;
      tql_pkg::S_FILL:      if (sts_i.fill_last) state_d = after_touch;
      tql_pkg::S_MASK:      state_d = tql_pkg::S_DECIDE;
      tql_pkg::S_DECIDE: begin
        if (!sts_i.explore) state_d = tql_pkg::S_SCAN_INIT;
        else if (sts_i.cnt_zero) state_d = tql_pkg::S_DONE;
        else state_d = tql_pkg::S_DIV;
      end
      tql_pkg::S_DIV:       if (sts_i.div_last) state_d = tql_pkg::S_SCAN_INIT;
      tql_pkg::S_SCAN_INIT: state_d = tql_pkg::S_SCAN;
      tql_pkg::S_SCAN:      if (sts_i.scan_done) state_d = tql_pkg::S_DONE;
      tql_pkg::S_OLD_RD:    state_d = tql_pkg::S_TGT;
      tql_pkg::S_TGT:       state_d = tql_pkg::S_MUL2;
      tql_pkg::S_MUL2:      state_d = tql_pkg::S_WB;
      tql_pkg::S_WB:        state_d = tql_pkg::S_DONE;
      tql_pkg::S_DONE:      if (!out_valid_q || out_ready_i) state_d = tql_pkg::S_IDLE;
      default:              state_d = tql_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tql_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      tql_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tql_pkg::S_NS_RD: cmd_o.ns_rd = 1'b1;
      tql_pkg::S_NS_CHK: begin
        cmd_o.avail_ld   = sts_i.seen;
        cmd_o.scan_start = sts_i.seen;
        cmd_o.use_ns     = 1'b1;
      end
      tql_pkg::S_NS_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.use_ns   = 1'b1;
        cmd_o.mq_ld    = sts_i.scan_done;
      end
      tql_pkg::S_TCH_RD:  cmd_o.tch_rd = 1'b1;
      tql_pkg::S_TCH_CHK: cmd_o.avail_ld = sts_i.seen;
      tql_pkg::S_FILL: begin
        cmd_o.fill = 1'b1;
        cmd_o.mark = sts_i.fill_last;
      end
      tql_pkg::S_MASK:   cmd_o.mask_wr = 1'b1;
      tql_pkg::S_DECIDE: cmd_o.div_start = sts_i.explore && !sts_i.cnt_zero;
      tql_pkg::S_DIV:    cmd_o.div_run = 1'b1;
      tql_pkg::S_SCAN_INIT: begin
        cmd_o.scan_start = 1'b1;
        cmd_o.sel_mode   = sts_i.explore;
      end
      tql_pkg::S_SCAN: cmd_o.scan_run = 1'b1;
      tql_pkg::S_OLD_RD: begin
        cmd_o.old_rd   = 1'b1;
        cmd_o.mul_disc = 1'b1;
      end
      tql_pkg::S_TGT:  cmd_o.tgt_ld = 1'b1;
      tql_pkg::S_MUL2: cmd_o.mul_alpha = 1'b1;
      tql_pkg::S_WB:   cmd_o.q_wb = 1'b1;
      tql_pkg::S_DONE: cmd_o.res_ld = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.res_ld) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tql_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: src/tql_dp.sv
// ----------------------------------------------------------------------------
// Q-learning datapath
// Table memories, row scan, remainder unit, multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tql_pkg::cfg_t     cfg_i,
  input  wire tql_pkg::in_item_t in_data_i,
  input  wire tql_pkg::cmd_t     cmd_i,
  output tql_pkg::sts_t          sts_o,
  output tql_pkg::out_item_t     out_data_o
);

  localparam int SW = tql_pkg::STATE_W;
  localparam int AW = tql_pkg::ACT_W;
  localparam int CW = tql_pkg::CNT_W;
  localparam int NA = tql_pkg::MAX_ACTIONS;
  localparam int QW = tql_pkg::Q_W;

  tql_pkg::in_item_t item_q;
  logic [NA-1:0]        avail_cur_q;
  logic                 found_q, mode_q, pend_v_q;
  logic signed [QW-1:0] best_q, mq_q, tgt_q, old_q;
  logic [AW-1:0]        arg_q, pend_idx_q, fill_i_q;
  logic [CW-1:0]        scan_i_q, k_q, cnt_q, rem_q;
  logic [tql_pkg::DRAW_IDX_W-1:0] div_i_q;
  logic [SW-1:0]        clr_q;
  logic signed [tql_pkg::PROD_W-1:0] prod_q;
  tql_pkg::out_item_t   res_q;

  logic [SW-1:0]        s_idx, ns_idx;
  logic [CW-1:0]        n_used;
  logic [NA-1:0]        used_mask, avail_new;
  logic                 seen_rd;
  logic [NA-1:0]        avail_rd;
  logic signed [QW-1:0] q_rd;
  logic                 issue;
  logic [CW:0]          trial;
  logic [CW:0]          trial_sub;
  logic signed [32:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [tql_pkg::PROD_W-1:0]   rounded;
  logic signed [tql_pkg::SCALED_W-1:0] scaled;
  logic signed [tql_pkg::WIDE_W-1:0]   tgt_raw, nv_raw;
  logic signed [QW-1:0] nv;

  assign s_idx  = item_q.state_index[SW-1:0];
  assign ns_idx = item_q.next_state_index[SW-1:0];
  assign n_used = tql_pkg::used_count(cfg_i.actions_in_use);

  always_comb begin
    for (int i = 0; i < NA; i++) used_mask[i] = (CW'(i) < n_used);
  end

  // Only actions in use lose availability when their mask bit is low.
  assign avail_new = avail_cur_q & ~(used_mask & ~item_q.action_mask);

  tql_ram #(.WIDTH(1), .DEPTH(tql_pkg::NUM_STATES)) u_seen (
    .clk_i,
    .we_i    (cmd_i.clear | cmd_i.mark),
    .waddr_i (cmd_i.clear ? clr_q : s_idx),
    .wdata_i (~cmd_i.clear),
    .re_i    (cmd_i.ns_rd | cmd_i.tch_rd),
    .raddr_i (cmd_i.ns_rd ? ns_idx : s_idx),
    .rdata_o (seen_rd)
  );

  tql_ram #(.WIDTH(NA), .DEPTH(tql_pkg::NUM_STATES)) u_avail (
    .clk_i,
    .we_i    (cmd_i.mark | cmd_i.mask_wr),
    .waddr_i (s_idx),
    .wdata_i (cmd_i.mark ? {NA{1'b1}} : avail_new),
    .re_i    (cmd_i.ns_rd | cmd_i.tch_rd),
    .raddr_i (cmd_i.ns_rd ? ns_idx : s_idx),
    .rdata_o (avail_rd)
  );

  assign issue = scan_i_q < n_used;

  tql_ram #(.WIDTH(QW), .DEPTH(tql_pkg::Q_DEPTH)) u_q (
    .clk_i,
    .we_i    (cmd_i.fill | cmd_i.q_wb),
    .waddr_i ({s_idx, cmd_i.fill ? fill_i_q : item_q.action_taken[AW-1:0]}),
    .wdata_i (cmd_i.fill ? cfg_i.starting_value : nv),
    .re_i    ((cmd_i.scan_run & issue) | cmd_i.old_rd),
    .raddr_i (cmd_i.old_rd ? {s_idx, item_q.action_taken[AW-1:0]}
                           : {cmd_i.use_ns ? ns_idx : s_idx, scan_i_q[AW-1:0]}),
    .rdata_o (q_rd)
  );

  // Remainder unit: one dividend bit per cycle, most significant first.
  assign trial     = {rem_q, item_q.pick_draw[4'(tql_pkg::DRAW_W - 1) - div_i_q]};
  assign trial_sub = (trial >= {1'b0, cnt_q}) ? trial - {1'b0, cnt_q} : trial;

  // Shared multiplier and rounding to the nearest LSB, ties upward.
  always_comb begin
    if (cmd_i.mul_alpha) begin
      mul_a = 33'(tgt_q) - 33'(old_q);
      mul_b = {1'b0, tql_pkg::sat_rate(cfg_i.learning_rate)};
    end else begin
      mul_a = 33'(mq_q);
      mul_b = {1'b0, tql_pkg::sat_rate(cfg_i.discount_factor)};
    end
  end

  assign rounded = prod_q + tql_pkg::PROD_W'(32768);
  assign scaled  = rounded[tql_pkg::PROD_W-1:16];
  assign tgt_raw = (cfg_i.rule_select == tql_pkg::RULE_STD)
                 ? tql_pkg::WIDE_W'(item_q.reward_value) + tql_pkg::WIDE_W'(scaled)
                 : tql_pkg::WIDE_W'(item_q.reward_value) - tql_pkg::WIDE_W'(scaled);
  assign nv_raw  = tql_pkg::WIDE_W'(old_q) + tql_pkg::WIDE_W'(scaled);
  assign nv      = tql_pkg::sat32(nv_raw);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      fill_i_q <= '0;
      scan_i_q <= '0;
      pend_v_q <= 1'b0;
      found_q  <= 1'b0;
      mode_q   <= 1'b0;
      div_i_q  <= '0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.accept) begin
        fill_i_q <= '0;
        found_q  <= 1'b0;
      end
      if (cmd_i.fill) fill_i_q <= fill_i_q + 1'b1;
      if (cmd_i.div_start) div_i_q <= '0;
      if (cmd_i.div_run) div_i_q <= div_i_q + 1'b1;
      if (cmd_i.scan_start) begin
        scan_i_q <= '0;
        pend_v_q <= 1'b0;
        found_q  <= 1'b0;
        mode_q   <= cmd_i.sel_mode;
      end
      if (cmd_i.scan_run) begin
        pend_v_q <= issue;
        if (issue) scan_i_q <= scan_i_q + 1'b1;
        if (pend_v_q && avail_cur_q[pend_idx_q]) begin
          if (mode_q) begin
            if (!found_q && k_q == '0) found_q <= 1'b1;
          end else if (!found_q || q_rd > best_q) begin
            found_q <= 1'b1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
      mq_q   <= '0;
    end
    if (cmd_i.avail_ld) avail_cur_q <= avail_rd;
    if (cmd_i.mark) avail_cur_q <= {NA{1'b1}};
    if (cmd_i.mask_wr) avail_cur_q <= avail_new;
    if (cmd_i.div_start) begin
      cnt_q <= tql_pkg::popcount(avail_cur_q & used_mask);
      rem_q <= '0;
    end
    if (cmd_i.div_run) rem_q <= trial_sub[CW-1:0];
    if (cmd_i.scan_start) k_q <= rem_q;
    if (cmd_i.scan_run) begin
      if (issue) pend_idx_q <= scan_i_q[AW-1:0];
      if (pend_v_q && avail_cur_q[pend_idx_q]) begin
        if (mode_q) begin
          if (!found_q) begin
            if (k_q == '0) arg_q <= pend_idx_q;
            else k_q <= k_q - 1'b1;
          end
        end else if (!found_q || q_rd > best_q) begin
          best_q <= q_rd;
          arg_q  <= pend_idx_q;
        end
      end
    end
    if (cmd_i.mq_ld) mq_q <= found_q ? best_q : '0;
    if (cmd_i.mul_disc || cmd_i.mul_alpha) prod_q <= tql_pkg::PROD_W'(mul_a * mul_b);
    if (cmd_i.tgt_ld) begin
      tgt_q <= tql_pkg::sat32(tgt_raw);
      old_q <= q_rd;
    end
    if (cmd_i.res_ld) begin
      if (item_q.kind == tql_pkg::KIND_UPDATE) begin
        res_q.chosen_action <= '0;
        res_q.status_code   <= sts_o.a_oor ? tql_pkg::ST_RANGE : tql_pkg::ST_OK;
      end else begin
        res_q.chosen_action <= found_q ? 4'(arg_q) : '0;
        res_q.status_code   <= found_q ? tql_pkg::ST_OK : tql_pkg::ST_NO_AVAIL;
      end
    end
  end

  always_comb begin
    sts_o.clr_last  = &clr_q;
    sts_o.kind      = item_q.kind;
    sts_o.ended     = item_q.episode_ended;
    sts_o.seen      = seen_rd;
    sts_o.fill_last = (fill_i_q == AW'(NA - 1));
    sts_o.explore   = item_q.training_on &&
                      ({1'b0, item_q.explore_draw} < tql_pkg::sat_rate(cfg_i.explore_rate));
    sts_o.cnt_zero  = (tql_pkg::popcount(avail_cur_q & used_mask) == '0);
    sts_o.div_last  = (div_i_q == tql_pkg::DRAW_IDX_W'(tql_pkg::DRAW_W - 1));
    sts_o.scan_done = !pend_v_q && !issue;
    sts_o.a_oor     = ({1'b0, item_q.action_taken} >= n_used);
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

FILE: src/tabular_q_learning_agent.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent
// Epsilon-greedy action choice and saturating Q16.16 learning updates.
// ----------------------------------------------------------------------------
// From input transfer to result, an act fills its row with the starting value on
// first touch, applies its mask and scans the actions in use; when it explores it
// first divides the pick draw by the count of available actions, and it ends at once
// if none is available. An update scans a live, seen next-state row, fills its own
// row on first touch and, if its action is in range, blends and writes back one entry.
// Items go one at a time, and none is taken while the seen flags clear after reset.
`default_nettype none

module tabular_q_learning_agent (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tql_in_if.sink                             in_i,
  tql_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tql_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tql_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tql_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  tql_pkg::cfg_t cfg_q;
  tql_pkg::cmd_t cmd;
  tql_pkg::sts_t sts;
  logic          cfg_wr;
  logic [tql_pkg::REG_IDX_W-1:0] reg_idx;
  logic [tql_pkg::CNT_W-1:0]     n_used;

  // The configuration port has no wait states; a write lands in its access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[tql_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate   <= 17'd6554;
      cfg_q.discount_factor <= 17'd58982;
      cfg_q.explore_rate    <= 17'd6554;
      cfg_q.starting_value  <= '0;
      cfg_q.rule_select     <= tql_pkg::RULE_STD;
      cfg_q.actions_in_use  <= 5'd16;
    end else if (cfg_wr) begin
      case (reg_idx)
        tql_pkg::REG_LEARNING_RATE:   cfg_q.learning_rate   <= pwdata[16:0];
        tql_pkg::REG_DISCOUNT_FACTOR: cfg_q.discount_factor <= pwdata[16:0];
        tql_pkg::REG_EXPLORE_RATE:    cfg_q.explore_rate    <= pwdata[16:0];
        tql_pkg::REG_STARTING_VALUE:  cfg_q.starting_value  <= pwdata;
        tql_pkg::REG_RULE_SELECT:     cfg_q.rule_select     <= pwdata[0];
        tql_pkg::REG_ACTIONS_IN_USE:  cfg_q.actions_in_use  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Readback returns each register zero-extended.
  always_comb begin
    case (reg_idx)
      tql_pkg::REG_LEARNING_RATE:   prdata = 32'(cfg_q.learning_rate);
      tql_pkg::REG_DISCOUNT_FACTOR: prdata = 32'(cfg_q.discount_factor);
      tql_pkg::REG_EXPLORE_RATE:    prdata = 32'(cfg_q.explore_rate);
      tql_pkg::REG_STARTING_VALUE:  prdata = cfg_q.starting_value;
      tql_pkg::REG_RULE_SELECT:     prdata = 32'(cfg_q.rule_select);
      tql_pkg::REG_ACTIONS_IN_USE:  prdata = 32'(cfg_q.actions_in_use);
      default:                      prdata = '0;
    endcase
  end

  // The controller walks each item through its steps and owns both handshakes;
  // the datapath holds the tables and does the arithmetic.
  tql_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tql_dp u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_data_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_o.data)
  );

  assign n_used = tql_pkg::used_count(cfg_q.actions_in_use);

  // Items are processed one at a time, so a transfer in closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while an item is in progress");

  // A failing status always reports action zero.
  a_fail_action_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status_code != tql_pkg::ST_OK |->
      out_o.data.chosen_action == '0)
    else $error("nonzero action with failing status");

  // A successful result names an action in use.
  a_action_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.status_code == tql_pkg::ST_OK |->
      {1'b0, out_o.data.chosen_action} < n_used)
    else $error("chosen action beyond the actions in use");

endmodule

`default_nettype wire

FILE: sim/tb_tabular_q_learning_agent.sv
// ----------------------------------------------------------------------------
// Tabular Q-learning agent testbench
// Drives act and update items with random handshake gaps, predicts each result
// from a local copy of the Q table and configuration, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tabular_q_learning_agent;
  import tql_pkg::*;

  // Scoreboard: holds the results that accepted items are due to produce.
  class action_scoreboard;
    out_item_t pending_results[$];
    int unsigned errors;

    task report(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void note_item(input out_item_t res);
      pending_results.insert(pending_results.size(), res);
    endfunction

    task check_result(input out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no item waiting: action %0d status %0d",
                         got.chosen_action, got.status_code));
      end else begin
        want = pending_results.pop_front();
        if (got.chosen_action !== want.chosen_action) begin
          report($sformatf("chosen_action got %0d want %0d", got.chosen_action,
                           want.chosen_action));
        end
        if (got.status_code !== want.status_code) begin
          report($sformatf("status_code got %0d want %0d", got.status_code,
                           want.status_code));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tql_in_if in_ch ();
  tql_out_if out_ch ();

  tabular_q_learning_agent dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  action_scoreboard sb;

  // Local copy of the agent's state and registers.
  logic [RATE_W-1:0] alpha_q, gamma_q, eps_q;
  logic signed [31:0] init_q;
  logic rule_q;
  logic [4:0] nact_q;
  logic signed [31:0] q_table [NUM_STATES*MAX_ACTIONS];
  logic [MAX_ACTIONS-1:0] avail_table [NUM_STATES];
  logic seen_table [NUM_STATES];

  int stall_hold;      // Forced long receiver hold-off, in cycles.
  int unsigned busy_items;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  // Most gaps are short, a few long, and about a third are none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned rate_sat(input logic [RATE_W-1:0] r);
    return (r > RATE_W'(65536)) ? 65536 : int'(r);
  endfunction

  function automatic int unsigned act_count();
    if (nact_q == 0) return 1;
    if (nact_q > MAX_ACTIONS) return MAX_ACTIONS;
    return nact_q;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  // x times a Q16 fraction, rounded to nearest with ties upward.
  function automatic longint mul_frac(input longint x, input int unsigned f);
    longint p;
    p = x * longint'(f) + 32768;
    return p >>> 16;
  endfunction

  function automatic void touch_row(input int s);
    if (!seen_table[s]) begin
      for (int i = 0; i < MAX_ACTIONS; i++) q_table[s*MAX_ACTIONS+i] = init_q;
      avail_table[s] = '1;
      seen_table[s] = 1'b1;
    end
  endfunction

  // Best available Q in a row, or zero when none is available.
  function automatic logic best_q(input int s, output int a, output longint v);
    logic found;
    found = 1'b0;
    a = 0;
    v = 0;
    for (int i = 0; i < act_count(); i++)
      if (avail_table[s][i] && (!found || q_table[s*MAX_ACTIONS+i] > v)) begin
        v = q_table[s*MAX_ACTIONS+i];
        a = i;
        found = 1'b1;
      end
    return found;
  endfunction

  function automatic out_item_t predict_agent(input in_item_t it);
    out_item_t res;
    int s, ns, n, cnt, k, a;
    longint mq, disc, target, old, nv;
    logic found;
    res = '0;
    s = int'(it.state_index);
    n = act_count();
    if (it.kind == KIND_ACT) begin
      touch_row(s);
      for (int i = 0; i < n; i++)
        if (!it.action_mask[i]) avail_table[s][i] = 1'b0;
      if (it.training_on && int'(it.explore_draw) < rate_sat(eps_q)) begin
        cnt = 0;
        for (int i = 0; i < n; i++) cnt += int'(avail_table[s][i]);
        if (cnt == 0) res.status_code = ST_NO_AVAIL;
        else begin
          k = int'(it.pick_draw) % cnt;
          for (int i = 0; i < n; i++)
            if (avail_table[s][i]) begin
              if (k == 0) begin
                res.chosen_action = 4'(i);
                break;
              end
              k--;
            end
        end
      end else begin
        found = best_q(s, a, mq);
        if (found) res.chosen_action = 4'(a);
        else res.status_code = ST_NO_AVAIL;
      end
    end else begin
      ns = int'(it.next_state_index);
      mq = 0;
      if (!it.episode_ended && seen_table[ns]) found = best_q(ns, a, mq);
      touch_row(s);
      if (int'(it.action_taken) >= n) res.status_code = ST_RANGE;
      else begin
        disc = mul_frac(mq, rate_sat(gamma_q));
        target = clip32((rule_q == RULE_STD) ? longint'(it.reward_value) + disc
                                             : longint'(it.reward_value) - disc);
        old = q_table[s*MAX_ACTIONS+it.action_taken];
        nv = clip32(old + mul_frac(target - old, rate_sat(alpha_q)));
        q_table[s*MAX_ACTIONS+it.action_taken] = 32'(nv);
      end
    end
    return res;
  endfunction

  // APB write: setup cycle then access cycle; pready is always high.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEARNING_RATE: alpha_q = val[RATE_W-1:0];
      REG_DISCOUNT_FACTOR: gamma_q = val[RATE_W-1:0];
      REG_EXPLORE_RATE: eps_q = val[RATE_W-1:0];
      REG_STARTING_VALUE: init_q = val;
      REG_RULE_SELECT: rule_q = val[0];
      REG_ACTIONS_IN_USE: nact_q = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offers one item and waits for its transfer; prediction happens at accept.
  // Valid stays high after the transfer so that a following item with no gap
  // goes out without a second drive in the same step.
  task automatic send_item(input in_item_t it, input logic allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(predict_agent(it));
  endtask

  // Block is idle once every result has come; the task waits past that point.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item(input int state_span, input int wellformed);
    in_item_t it;
    it = '0;
    it.kind = 1'($urandom_range(0, 1));
    it.state_index = (state_span >= 4096) ? 12'($urandom) : 12'($urandom_range(0, state_span-1));
    it.next_state_index = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                : 12'($urandom_range(0, state_span-1));
    it.action_taken = wellformed ? 4'($urandom_range(0, act_count()-1)) : 4'($urandom);
    case ($urandom_range(0, 5))
      0: it.reward_value = 32'($urandom);
      1: it.reward_value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: it.reward_value = $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
    endcase
    it.episode_ended = ($urandom_range(0, 4) == 0);
    it.training_on = 1'($urandom_range(0, 1));
    // Masks mostly keep actions; sometimes clear a few or many.
    case ($urandom_range(0, 9))
      0: it.action_mask = 16'($urandom);
      1: it.action_mask = 16'h0000;
      default: it.action_mask = ~(16'(1) << $urandom_range(0, 15)) | 16'($urandom_range(0,1) ? 16'hFFFF : 16'hEFFF);
    endcase
    it.explore_draw = 16'($urandom);
    it.pick_draw = 16'($urandom);
    return it;
  endfunction

  // Result side: random gaps in ready, plus one forced long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_hold > 0) begin
        out_ch.ready <= 1'b0;
        stall_hold--;
      end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
      end else if (!out_ch.ready) begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

  initial begin
    in_item_t it;
    int span;
    sb = new();
    stall_hold = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    alpha_q = 17'd6554;
    gamma_q = 17'd58982;
    eps_q = 17'd6554;
    init_q = 0;
    rule_q = RULE_STD;
    nact_q = 5'd16;
    for (int i = 0; i < NUM_STATES; i++) seen_table[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: extremes of fields, each status, explore and exploit.
    write_reg(REG_EXPLORE_RATE, 32'd65536);
    it = '0;
    it.kind = KIND_ACT; it.state_index = 12'd0; it.action_mask = 16'hFFFF;
    it.training_on = 1'b1; it.pick_draw = 16'hFFFF;
    send_item(it, 1'b0);
    it.action_mask = 16'h0000;                       // row becomes unavailable
    send_item(it, 1'b0);
    it.kind = KIND_UPDATE; it.next_state_index = 12'd0; it.action_taken = 4'd3;
    it.reward_value = 32'sh7FFFFFFF;                 // next row fully unavailable
    send_item(it, 1'b0);
    it.state_index = 12'hFFF; it.next_state_index = 12'hFFE; it.reward_value = 32'sh80000000;
    it.action_taken = 4'hF; it.episode_ended = 1'b1;
    send_item(it, 1'b0);
    it.kind = KIND_ACT; it.training_on = 1'b0; it.action_mask = 16'hAAAA;
    it.explore_draw = 16'hFFFF; it.pick_draw = 16'h0;
    send_item(it, 1'b0);
    drain();
    write_reg(REG_ACTIONS_IN_USE, 32'd0);            // clamps to one action
    write_reg(REG_STARTING_VALUE, 32'h80000000);
    write_reg(REG_RULE_SELECT, 32'd1);
    write_reg(REG_LEARNING_RATE, 32'h1FFFF);
    write_reg(REG_DISCOUNT_FACTOR, 32'd65536);
    it = '0;
    it.kind = KIND_UPDATE; it.state_index = 12'd7; it.next_state_index = 12'd9;
    it.action_taken = 4'd1; it.reward_value = 32'sh7FFFFFFF;
    send_item(it, 1'b0);                             // action out of range
    it.action_taken = 4'd0;
    send_item(it, 1'b0);
    it.kind = KIND_ACT; it.state_index = 12'd9; it.action_mask = 16'hFFFF;
    it.training_on = 1'b1; it.explore_draw = 16'd0;
    send_item(it, 1'b0);
    it.kind = KIND_UPDATE; it.state_index = 12'd9; it.next_state_index = 12'd7;
    it.reward_value = 32'sh80000000;
    send_item(it, 1'b0);
    drain();
    write_reg(REG_ACTIONS_IN_USE, 32'd31);           // clamps to sixteen
    write_reg(REG_STARTING_VALUE, 32'h7FFFFFFF);
    write_reg(REG_LEARNING_RATE, 32'd0);
    write_reg(REG_DISCOUNT_FACTOR, 32'd0);
    write_reg(REG_EXPLORE_RATE, 32'd0);
    it = '0;
    it.kind = KIND_ACT; it.state_index = 12'd100; it.action_mask = 16'h8001;
    it.training_on = 1'b1;
    send_item(it, 1'b0);
    it.kind = KIND_UPDATE; it.next_state_index = 12'd100; it.action_taken = 4'd15;
    send_item(it, 1'b0);
    drain();

    // Random phases with varied settings; small state spans revisit rows.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LEARNING_RATE, (ph == 5) ? 32'd65536 : 32'($urandom_range(0, 70000)));
      write_reg(REG_DISCOUNT_FACTOR, 32'($urandom_range(0, 131071)));
      write_reg(REG_EXPLORE_RATE, (ph == 4) ? 32'h1FFFF : 32'($urandom_range(0, 40000)));
      write_reg(REG_STARTING_VALUE, 32'($signed(32'($urandom_range(0, 131072))) - 65536));
      write_reg(REG_RULE_SELECT, 32'(ph & 1));
      write_reg(REG_ACTIONS_IN_USE, 32'($urandom_range(1, 16)));
      span = (ph == 3) ? 4096 : $urandom_range(4, 40);
      for (int k = 0; k < 305; k++) begin
        it = rand_item(span, $urandom_range(0, 9) != 0);
        if (ph == 1 && k == 50) stall_hold = 300;    // receiver holds off long
        send_item(it, (ph != 2) || (k < 100));
      end
      // Sender pauses until every result is in before the next setting.
      drain();
    end

    if (sb.pending_results.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: tabular_q_learning_agent.f
src/tql_pkg.sv
src/tql_in_if.sv
src/tql_out_if.sv
src/tql_ram.sv
src/tql_ctrl.sv
src/tql_dp.sv
src/tabular_q_learning_agent.sv
sim/tb_tabular_q_learning_agent.sv
